### rtl/fpa_pkg.sv
// shared types and constants for the q24.8 fixed-point alu
package fpa_pkg;

  localparam int FracBitsDefault = 8;
  localparam int DataW = 32;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_DIV  = 4'd3,
    OP_LT   = 4'd4,
    OP_GT   = 4'd5,
    OP_LE   = 4'd6,
    OP_GE   = 4'd7,
    OP_EQ   = 4'd8,
    OP_NE   = 4'd9,
    OP_MIN  = 4'd10,
    OP_MAX  = 4'd11,
    OP_INC  = 4'd12,
    OP_DEC  = 4'd13,
    OP_FROM = 4'd14,
    OP_TOI  = 4'd15
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIVZ = 2'd2
  } status_t;

  // side information that rides along the divider pipeline
  typedef struct packed {
    logic             is_div;
    logic             neg;
    logic             divz;
    logic [DataW-1:0] value;
    logic             cmp;
    status_t          status;
  } sb_t;

endpackage

### rtl/fpa_if.sv
// request and response channel interfaces
interface fpa_req_if (input logic clk);
  logic               valid;
  logic               ready;
  logic [3:0]         operation;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;

  modport source (output valid, operation, operand_a, operand_b, input ready);
  modport sink (input valid, operation, operand_a, operand_b, output ready);
endinterface

interface fpa_rsp_if (input logic clk);
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic               compare_true;
  logic [1:0]         status;

  modport source (output valid, result_value, compare_true, status, input ready);
  modport sink (input valid, result_value, compare_true, status, output ready);
endinterface

### rtl/fpa_div.sv
// pipelined restoring divider, one quotient bit per stage
module fpa_div #(
  parameter int QW = fpa_pkg::DataW + fpa_pkg::FracBitsDefault
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [QW-1:0]             dividend,
  input  logic [fpa_pkg::DataW-1:0] divisor,
  input  fpa_pkg::sb_t              in_sb,
  output logic                      out_valid,
  output logic [QW-1:0]             quotient,
  output fpa_pkg::sb_t              out_sb
);
  localparam int W = fpa_pkg::DataW;

  logic               v   [0:QW];
  logic [QW-1:0]      nq  [0:QW];
  logic [W-1:0]       rem [0:QW];
  logic [W-1:0]       d   [0:QW];
  fpa_pkg::sb_t       sb  [0:QW];

  assign v[0]   = in_valid;
  assign nq[0]  = dividend;
  assign rem[0] = '0;
  assign d[0]   = divisor;
  assign sb[0]  = in_sb;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [W:0] trial;
    logic       fits;
    assign trial = {rem[k], nq[k][QW-1]};
    assign fits  = trial >= {1'b0, d[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= fits ? W'(trial - {1'b0, d[k]}) : W'(trial);
        nq[k+1]  <= {nq[k][QW-2:0], fits};
        d[k+1]   <= d[k];
        sb[k+1]  <= sb[k];
      end
    end
  end

  assign out_valid = v[QW];
  assign quotient  = nq[QW];
  assign out_sb    = sb[QW];
endmodule

### rtl/fixed_point_q24_8_alu.sv
// top level of the pipelined signed q24.8 fixed-point alu
//
//   channel  dir  fields
//   req      in   operation[3:0], operand_a[31:0], operand_b[31:0]
//   rsp      out  result_value[31:0], compare_true, status[1:0]
//
// one word accepted per cycle while rsp is not stalled; every word passes the input
// register, stages 1 and 2, the bit-per-stage divider and the output register
// synchronous reset clears the valid bits only
// a stalled rsp freezes the whole pipeline; req.ready drops with it
module fixed_point_q24_8_alu #(
  parameter int FRAC_BITS = fpa_pkg::FracBitsDefault
) (
  input logic        clk,
  input logic        rst,
  fpa_req_if.sink    req,
  fpa_rsp_if.source  rsp
);
  localparam int W  = fpa_pkg::DataW;
  localparam int QW = W + FRAC_BITS;
  localparam logic [63:0] RND64 = (64'(1) << FRAC_BITS) - 64'(1);
  localparam logic [W:0]  RND33 = (33'(1) << FRAC_BITS) - 33'(1);

  logic advance;
  assign advance   = !rsp.valid || rsp.ready;
  assign req.ready = advance;

  // stage 0: input register
  logic               v0;
  fpa_pkg::op_t       op0;
  logic signed [W-1:0] a0, b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (advance) begin
      v0 <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      op0 <= fpa_pkg::op_t'(req.operation);
      a0  <= req.operand_a;
      b0  <= req.operand_b;
    end
  end

  // stage 1: simple ops, product, magnitudes
  logic signed [W:0]      sum, dif, incv, decv, toi;
  logic signed [QW-1:0]   fi;
  logic [W-1:0]           r_next;
  logic                   c_next;
  fpa_pkg::status_t       s_next;
  logic                   lt;

  assign sum  = {a0[W-1], a0} + {b0[W-1], b0};
  assign dif  = {a0[W-1], a0} - {b0[W-1], b0};
  assign incv = {a0[W-1], a0} + 33'sd1;
  assign decv = {a0[W-1], a0} - 33'sd1;
  assign fi   = {a0, FRAC_BITS'(0)};
  assign toi  = $signed({a0[W-1], a0} + (a0[W-1] ? RND33 : '0)) >>> FRAC_BITS;
  assign lt   = a0 < b0;

  always_comb begin
    logic signed [W:0] w;
    w      = '0;
    r_next = '0;
    c_next = 1'b0;
    s_next = fpa_pkg::ST_OK;
    case (op0)
      fpa_pkg::OP_ADD: w = sum;
      fpa_pkg::OP_SUB: w = dif;
      fpa_pkg::OP_INC: w = incv;
      fpa_pkg::OP_DEC: w = decv;
      default: w = '0;
    endcase
    case (op0) inside
      fpa_pkg::OP_ADD, fpa_pkg::OP_SUB, fpa_pkg::OP_INC, fpa_pkg::OP_DEC: begin
        if (w[W] != w[W-1]) begin
          r_next = w[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
          s_next = fpa_pkg::ST_SAT;
        end else begin
          r_next = w[W-1:0];
        end
      end
      fpa_pkg::OP_FROM: begin
        if ((&fi[QW-1:W-1]) || !(|fi[QW-1:W-1])) begin
          r_next = fi[W-1:0];
        end else begin
          r_next = fi[QW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
          s_next = fpa_pkg::ST_SAT;
        end
      end
      fpa_pkg::OP_TOI: r_next = toi[W-1:0];
      fpa_pkg::OP_LT:  c_next = lt;
      fpa_pkg::OP_GT:  c_next = b0 < a0;
      fpa_pkg::OP_LE:  c_next = !(b0 < a0);
      fpa_pkg::OP_GE:  c_next = !lt;
      fpa_pkg::OP_EQ:  c_next = a0 == b0;
      fpa_pkg::OP_NE:  c_next = a0 != b0;
      fpa_pkg::OP_MIN: r_next = lt ? a0 : b0;
      fpa_pkg::OP_MAX: r_next = (b0 < a0) ? a0 : b0;
      default: r_next = '0;
    endcase
  end

  logic                v1;
  fpa_pkg::op_t        op1;
  logic [W-1:0]        r1;
  logic                c1;
  fpa_pkg::status_t    s1;
  logic signed [63:0]  prod1;
  logic [W-1:0]        abs_a1, abs_b1;
  logic                neg1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (advance) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      op1    <= op0;
      r1     <= r_next;
      c1     <= c_next;
      s1     <= s_next;
      prod1  <= a0 * b0;
      abs_a1 <= a0[W-1] ? W'(-a0) : W'(a0);
      abs_b1 <= b0[W-1] ? W'(-b0) : W'(b0);
      neg1   <= a0[W-1] ^ b0[W-1];
    end
  end

  // stage 2: scale and saturate the product, build divider side data
  logic signed [63:0] pscaled;
  fpa_pkg::sb_t       sb_next;

  assign pscaled = $signed(prod1 + (prod1[63] ? RND64 : '0)) >>> FRAC_BITS;

  always_comb begin
    sb_next        = '0;
    sb_next.is_div = op1 == fpa_pkg::OP_DIV;
    sb_next.neg    = neg1;
    sb_next.divz   = abs_b1 == '0;
    sb_next.value  = r1;
    sb_next.cmp    = c1;
    sb_next.status = s1;
    if (op1 == fpa_pkg::OP_MUL) begin
      if ((&pscaled[63:W-1]) || !(|pscaled[63:W-1])) begin
        sb_next.value = pscaled[W-1:0];
      end else begin
        sb_next.value  = pscaled[63] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        sb_next.status = fpa_pkg::ST_SAT;
      end
    end
  end

  logic          v2;
  fpa_pkg::sb_t  sb2;
  logic [W-1:0]  abs_a2, abs_b2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (advance) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sb2    <= sb_next;
      abs_a2 <= abs_a1;
      abs_b2 <= abs_b1;
    end
  end

  logic          vd;
  logic [QW-1:0] q;
  fpa_pkg::sb_t  sbd;

  fpa_div #(.QW(QW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .in_valid  (v2),
    .dividend  ({abs_a2, FRAC_BITS'(0)}),
    .divisor   (abs_b2),
    .in_sb     (sb2),
    .out_valid (vd),
    .quotient  (q),
    .out_sb    (sbd)
  );

  // final stage: sign and saturate the quotient or flag a zero divisor, output register
  logic signed [QW:0] qs;
  logic [W-1:0]       fv;
  fpa_pkg::status_t   fs;

  assign qs = sbd.neg ? -$signed({1'b0, q}) : $signed({1'b0, q});

  always_comb begin
    fv = sbd.value;
    fs = sbd.status;
    if (sbd.is_div) begin
      if (sbd.divz) begin
        fv = '0;
        fs = fpa_pkg::ST_DIVZ;
      end else if ((&qs[QW:W-1]) || !(|qs[QW:W-1])) begin
        fv = qs[W-1:0];
        fs = fpa_pkg::ST_OK;
      end else begin
        fv = qs[QW] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        fs = fpa_pkg::ST_SAT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (advance) begin
      rsp.valid <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp.result_value <= fv;
      rsp.compare_true <= sbd.cmp;
      rsp.status       <= fs;
    end
  end
endmodule
